@@ sv/chs_pkg.sv @@
// types and constants shared by the spline interpolator modules
package chs_pkg;

  localparam int ACC_W  = 128;
  localparam int MULT_W = 33;
  localparam int STEP_W = 6;
  localparam int T_W    = 17;

  localparam logic [STEP_W-1:0] DX_STEPS = STEP_W'(MULT_W);
  localparam logic [STEP_W-1:0] T_STEPS  = STEP_W'(T_W);

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_FEW   = 3'd2,
    ST_ORDER = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } mac_req_t;

endpackage

@@ sv/chs_mac.sv @@
// shared shift-add multiply-accumulate unit, one multiplier bit per cycle
module chs_mac import chs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_req_t                req,
  input  logic signed [ACC_W-1:0] init,
  input  logic signed [ACC_W-1:0] mcand,
  input  logic [MULT_W-1:0]       mult,
  output logic                    done,
  output logic signed [ACC_W-1:0] acc
);

  logic                    busy;
  logic [STEP_W-1:0]       cnt;
  logic signed [ACC_W-1:0] mc;
  logic [MULT_W-1:0]       ml;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= init;
      mc  <= mcand;
      ml  <= mult;
      cnt <= req.steps;
    end else if (busy) begin
      if (ml[0]) begin
        acc <= acc + mc;
      end
      mc  <= mc <<< 1;
      ml  <= ml >> 1;
      cnt <= cnt - STEP_W'(1);
    end
  end

endmodule

@@ sv/cubic_hermite_spline_interpolator_core.sv @@
// top level of the cubic hermite spline interpolator over a loadable knot table
// Knots (x, y, slope in signed Q16.16) are appended one item at a time into a table of
// MAX_KNOTS entries; an evaluate item binary-searches the table for its section,
// divides out t in Q1.16 by a bit-serial restoring divider and then evaluates the Hermite
// cubic in Horner form on one shared shift-add multiply-accumulate unit of 128 bits,
// flooring to Q16.16 and saturating to VALUE_WIDTH bits. Every item yields exactly one
// result item. Appends and error answers skip the search and arithmetic and go straight to
// the done state; a successful evaluation spends almost all its time in the bit-serial
// multiplier (two 33-step slope products and three 17-step Horner steps). One item is
// worked on at a time, but a new item is taken while a finished result still waits in the
// output register. The table needs no clearing after reset.
module cubic_hermite_spline_interpolator_core import chs_pkg::*; #(
  parameter int MAX_KNOTS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic                          restart,
  input  logic signed [31:0]            knot_x,
  input  logic signed [31:0]            knot_y,
  input  logic signed [31:0]            knot_slope,
  input  logic signed [31:0]            query_x,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic [2:0]                    status,
  output logic [5:0]                    section
);

  localparam int IW = $clog2(MAX_KNOTS);
  localparam int CW = $clog2(MAX_KNOTS + 1);
  localparam int VW = VALUE_WIDTH;

  // sequencer states
  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_PROBE = 16'h0002,
    S_CMP   = 16'h0004,
    S_LD1   = 16'h0008,
    S_LD2   = 16'h0010,
    S_DIV   = 16'h0020,
    S_MD1   = 16'h0040,
    S_MD2   = 16'h0080,
    S_AB1   = 16'h0100,
    S_AB2   = 16'h0200,
    S_HGO   = 16'h0400,
    S_H1    = 16'h0800,
    S_H2    = 16'h1000,
    S_H3    = 16'h2000,
    S_DONE  = 16'h4000,
    S_SPARE = 16'h8000
  } state_t;

  state_t state, state_next;

  // knot table, one row holds {x, y, slope}
  logic [95:0]   mem [MAX_KNOTS];
  logic [95:0]   rd_data;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;

  logic [CW-1:0]     count;
  logic signed [31:0] first_x, last_x;

  // search and section registers
  logic signed [31:0] q;
  logic [IW-1:0]      lo, hi, mid;
  logic [IW:0]        msum;
  logic [IW-1:0]      mid_c;

  // section operands
  logic signed [31:0] x1, y1, m1, m2;
  logic signed [32:0] e;
  logic [32:0]        dx;
  logic [33:0]        rem;
  logic [T_W-1:0]     t;
  logic [4:0]         dcnt;
  logic signed [64:0] d1, d2;
  logic signed [67:0] a, b;

  // results waiting for the output register
  logic signed [VW-1:0] res_value;
  status_t              res_status;
  logic [5:0]           res_section;

  // mac unit
  mac_req_t                mac_req;
  logic signed [ACC_W-1:0] mac_init, mac_mcand, mac_acc;
  logic [MULT_W-1:0]       mac_mult;
  logic                    mac_done;

  // item decode in idle
  logic               in_acc;
  logic [CW-1:0]      count_eff;
  logic               full, order_bad, store;
  logic               few, out_rng;
  logic               out_free;
  logic signed [31:0] rd_x;

  // divider step and saturation
  logic        div_ge;
  logic [33:0] div_sub;
  logic signed [34:0]   e3;
  logic signed [63:0]   top;
  logic                 fits;
  logic signed [VW-1:0] sat;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign count_eff = restart ? '0 : count;
  assign full      = (count_eff == CW'(MAX_KNOTS));
  assign order_bad = (count_eff != '0) && (knot_x <= last_x);
  assign store     = in_acc && !mode && !full && !order_bad;
  assign wr_addr   = IW'(count_eff);

  assign few     = (count < CW'(2));
  assign out_rng = (query_x < first_x) || (query_x > last_x);

  assign msum  = {1'b0, lo} + {1'b0, hi} + (IW+1)'(1);
  assign mid_c = msum[IW:1];
  assign rd_x  = rd_data[95:64];

  assign div_ge  = (rem >= {1'b0, dx});
  assign div_sub = div_ge ? (rem - {1'b0, dx}) : rem;

  assign e3 = {{2{e[32]}}, e} + {e[32], e, 1'b0};

  // floor to Q16.16 is the upper half of the 2^-80 sum
  assign top  = mac_acc[ACC_W-1:64];
  assign fits = (&top[63:VW-1]) || !(|top[63:VW-1]);
  assign sat  = fits ? top[VW-1:0]
                     : (top[63] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}});

  always_comb begin
    case (state)
      S_PROBE: rd_addr = (lo < hi) ? mid_c : lo;
      S_LD1:   rd_addr = lo + IW'(1);
      default: rd_addr = lo;
    endcase
  end

  // sequencer and mac launches
  always_comb begin
    state_next = state;
    mac_req    = '0;
    mac_init   = '0;
    mac_mcand  = '0;
    mac_mult   = '0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (!mode || few || out_rng) state_next = S_DONE;
          else state_next = S_PROBE;
        end
      end
      S_PROBE: state_next = (lo < hi) ? S_CMP : S_LD1;
      S_CMP:   state_next = S_PROBE;
      S_LD1:   state_next = S_LD2;
      S_LD2:   state_next = S_DIV;
      S_DIV: begin
        if (dcnt == 5'd1) begin
          state_next    = S_MD1;
          mac_req.start = 1'b1;
          mac_req.steps = DX_STEPS;
          mac_mcand     = {{96{m1[31]}}, m1};
          mac_mult      = dx;
        end
      end
      S_MD1: begin
        if (mac_done) begin
          state_next    = S_MD2;
          mac_req.start = 1'b1;
          mac_req.steps = DX_STEPS;
          mac_mcand     = {{96{m2[31]}}, m2};
          mac_mult      = dx;
        end
      end
      S_MD2: if (mac_done) state_next = S_AB1;
      S_AB1: state_next = S_AB2;
      S_AB2: state_next = S_HGO;
      S_HGO: begin
        state_next    = S_H1;
        mac_req.start = 1'b1;
        mac_req.steps = T_STEPS;
        mac_init      = {{44{b[67]}}, b, 16'b0};
        mac_mcand     = {{60{a[67]}}, a};
        mac_mult      = {16'b0, t};
      end
      S_H1: begin
        if (mac_done) begin
          state_next    = S_H2;
          mac_req.start = 1'b1;
          mac_req.steps = T_STEPS;
          mac_init      = {{31{d1[64]}}, d1, 32'b0};
          mac_mcand     = mac_acc;
          mac_mult      = {16'b0, t};
        end
      end
      S_H2: begin
        if (mac_done) begin
          state_next    = S_H3;
          mac_req.start = 1'b1;
          mac_req.steps = T_STEPS;
          mac_init      = {{32{y1[31]}}, y1, 64'b0};
          mac_mcand     = mac_acc;
          mac_mult      = {16'b0, t};
        end
      end
      S_H3:   if (mac_done) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  chs_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .req   (mac_req),
    .init  (mac_init),
    .mcand (mac_mcand),
    .mult  (mac_mult),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (store) begin
        count <= count_eff + CW'(1);
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // knot table, registered read
  always_ff @(posedge clk) begin
    if (store) begin
      mem[wr_addr] <= {knot_x, knot_y, knot_slope};
    end
    rd_data <= mem[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (store) begin
          last_x <= knot_x;
          if (count_eff == '0) first_x <= knot_x;
        end
        if (in_acc) begin
          q           <= query_x;
          lo          <= '0;
          hi          <= IW'(count - CW'(2));
          res_value   <= '0;
          res_section <= '0;
          if (!mode) res_status <= full ? ST_FULL : (order_bad ? ST_ORDER : ST_OK);
          else if (few) res_status <= ST_FEW;
          else if (out_rng) res_status <= ST_RANGE;
          else res_status <= ST_OK;
        end
      end
      S_PROBE: mid <= mid_c;
      S_CMP: begin
        if (rd_x <= q) lo <= mid;
        else hi <= mid - IW'(1);
      end
      S_LD1: begin
        x1 <= rd_data[95:64];
        y1 <= rd_data[63:32];
        m1 <= rd_data[31:0];
      end
      S_LD2: begin
        m2   <= rd_data[31:0];
        dx   <= {rd_x[31], rd_x} - {x1[31], x1};
        e    <= {rd_data[63], rd_data[63:32]} - {y1[31], y1};
        rem  <= {1'b0, {q[31], q} - {x1[31], x1}};
        dcnt <= 5'(T_W);
      end
      S_DIV: begin
        rem  <= {div_sub[32:0], 1'b0};
        t    <= {t[T_W-2:0], div_ge};
        dcnt <= dcnt - 5'd1;
      end
      S_MD1: if (mac_done) d1 <= mac_acc[64:0];
      S_MD2: if (mac_done) d2 <= mac_acc[64:0];
      S_AB1: begin
        // cubic coefficient d1+d2-2dy and square coefficient 3dy-2d1-d2, dy in Q32
        a <= {{3{d1[64]}}, d1} + {{3{d2[64]}}, d2};
        b <= {{17{e3[34]}}, e3, 16'b0} - {{3{d2[64]}}, d2};
      end
      S_AB2: begin
        a <= a - {{18{e[32]}}, e, 17'b0};
        b <= b - {{2{d1[64]}}, d1, 1'b0};
      end
      S_H3: begin
        if (mac_done) begin
          res_value   <= sat;
          res_section <= 6'(lo);
        end
      end
      default: ;
    endcase
    if (state == S_DONE && out_free) begin
      value   <= res_value;
      status  <= res_status;
      section <= res_section;
    end
  end

  // the table never holds more knots than it has rows
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_KNOTS))
    else $error("knot count beyond table depth");

  // every probe lies above the low bound and at or below the high bound of the live search window
  a_probe_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (mid > lo && mid <= hi))
    else $error("search probe outside window");

  // the multiplier only finishes while the sequencer waits on it
  a_mac_owner: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == S_MD1 || state == S_MD2 || state == S_H1 ||
                  state == S_H2 || state == S_H3))
    else $error("multiplier finished outside a multiply step");

  // a result reaches the output register exactly as the sequencer leaves done
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result not loaded on leaving done");

endmodule

@@ tb/tb_cubic_hermite_spline_interpolator_core.sv @@
// self-checking testbench for the cubic hermite spline interpolator core
module tb_cubic_hermite_spline_interpolator_core;
  import chs_pkg::*;

  localparam int  KNOTS       = 64;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  TAIL_CYCLES = 400;
  localparam int  HOLD_CYCLES = 2000;
  localparam int  NUM_ITEMS   = 650;
  localparam bit  MODE_APPEND = 1'b0;
  localparam bit  MODE_EVAL   = 1'b1;
  localparam longint XMIN = -64'sd2147483648;
  localparam longint XMAX = 64'sd2147483647;

  typedef struct {
    bit          mode;
    bit          restart;
    logic [31:0] kx, ky, ks, qx;
    bit          pause;
  } knot_item_t;

  typedef struct {
    logic [31:0] value;
    status_t     status;
    logic [5:0]  section;
  } spline_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic restart = 1'b0;
  logic signed [31:0] knot_x = '0, knot_y = '0, knot_slope = '0, query_x = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] value;
  logic [2:0] status;
  logic [5:0] section;

  cubic_hermite_spline_interpolator_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .restart(restart), .knot_x(knot_x), .knot_y(knot_y),
    .knot_slope(knot_slope), .query_x(query_x),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .status(status), .section(section)
  );

  // stimulus waiting to be offered, and results still owed by the block
  knot_item_t  pending_items[$];
  spline_res_t owed_results[$];

  // shadow copy of the knot table
  logic [31:0] tab_x[KNOTS];
  logic [31:0] tab_y[KNOTS];
  logic [31:0] tab_m[KNOTS];
  int          tab_count = 0;

  int n_sent = 0, n_recv = 0, n_errors = 0, n_eval_ok = 0, n_err_status = 0;
  int cycles = 0;
  int tx_gap = 0, rx_gap = 0, hold_left = 0;
  bit hold_done = 1'b0;
  knot_item_t cur;

  initial forever #5 clk = ~clk;

  // quiet stretches: every third block of 100 items runs without idling
  function automatic bit calm();
    return ((n_sent / 100) % 3) == 0;
  endfunction

  // predicted result of each item from the shadow table, which appends update; hermite evaluation bit exact in 128 bits
  function automatic spline_res_t spline_predict(knot_item_t it);
    spline_res_t r;
    int lo, hi, mid;
    longint q, x1, dx, t, t2, t3, h00, h10, h01, h11, hv;
    longint unsigned num;
    logic signed [127:0] w0, w1, w2, w3, c0, c1, c2, c3, acc;
    r.value = '0;
    r.status = ST_OK;
    r.section = '0;
    if (it.mode == MODE_APPEND) begin
      if (it.restart) tab_count = 0;
      if (tab_count >= KNOTS) begin
        r.status = ST_FULL;
      end else if (tab_count > 0 && $signed(it.kx) <= $signed(tab_x[tab_count-1])) begin
        r.status = ST_ORDER;
      end else begin
        tab_x[tab_count] = it.kx;
        tab_y[tab_count] = it.ky;
        tab_m[tab_count] = it.ks;
        tab_count++;
      end
    end else begin
      q = longint'($signed(it.qx));
      if (tab_count < 2) begin
        r.status = ST_FEW;
      end else if (q < longint'($signed(tab_x[0])) ||
                   q > longint'($signed(tab_x[tab_count-1]))) begin
        r.status = ST_RANGE;
      end else begin
        lo = 0;
        hi = tab_count - 2;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          if (longint'($signed(tab_x[mid])) <= q) lo = mid;
          else hi = mid - 1;
        end
        x1 = longint'($signed(tab_x[lo]));
        dx = longint'($signed(tab_x[lo+1])) - x1;
        num = longint'(q - x1) << 16;
        t = longint'(num / longint'(unsigned'(dx)));
        t2 = t * t;
        t3 = t2 * t;
        h00 = 2 * t3 - 3 * t2 * 65536 + (64'sd1 <<< 48);
        h10 = t3 - 2 * t2 * 65536 + t * (64'sd1 <<< 32);
        h01 = 3 * t2 * 65536 - 2 * t3;
        h11 = t3 - t2 * 65536;
        w0 = 128'(h00); w1 = 128'(h01); w2 = 128'(h10); w3 = 128'(h11);
        c0 = 128'(longint'($signed(tab_y[lo]))) <<< 16;
        c1 = 128'(longint'($signed(tab_y[lo+1]))) <<< 16;
        c2 = 128'(dx) * 128'(longint'($signed(tab_m[lo])));
        c3 = 128'(dx) * 128'(longint'($signed(tab_m[lo+1])));
        acc = w0 * c0 + w1 * c1 + w2 * c2 + w3 * c3;
        hv = $signed(acc[127:64]);
        if (hv > XMAX) hv = XMAX;
        if (hv < XMIN) hv = XMIN;
        r.value = hv[31:0];
        r.section = lo[5:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got %h want %h", n_recv, what, got, want);
    n_errors++;
  endtask

  task automatic add_knot(bit rs, logic [31:0] x, logic [31:0] y, logic [31:0] s);
    knot_item_t it;
    it = '{mode: MODE_APPEND, restart: rs, kx: x, ky: y, ks: s,
           qx: $urandom, pause: 1'b0};
    pending_items.push_back(it);
  endtask

  task automatic add_query(logic [31:0] q);
    knot_item_t it;
    it = '{mode: MODE_EVAL, restart: 1'($urandom_range(0, 1)), kx: $urandom, ky: $urandom,
           ks: $urandom, qx: q, pause: 1'b0};
    pending_items.push_back(it);
  endtask

  task automatic add_pause();
    knot_item_t it;
    it = '{mode: MODE_APPEND, restart: 1'b0, kx: '0, ky: '0, ks: '0, qx: '0, pause: 1'b1};
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] rand_val();
    if ($urandom_range(0, 3) == 0) return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    return $urandom;
  endfunction

  // a restart followed by a run of increasing knots and some queries on them
  task automatic add_spline_run(bit fill);
    longint xs[$];
    longint xc, step, span, q;
    int n, nq, k;
    n = fill ? KNOTS + 2 : $urandom_range(2, 8);
    xc = fill ? XMIN + $urandom_range(0, 1 << 20) : longint'($signed($urandom));
    span = ($urandom_range(0, 1)) ? (1 << 16) : (1 << 26);
    if (fill) span = 1 << 24;
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        step = $urandom_range(1, int'(span));
        if (xc + step > XMAX) begin
          if (!fill) break;
          step = 1;
        end
        xc = xc + step;
      end
      xs.push_back(xc);
      add_knot(i == 0, xc[31:0], rand_val(), rand_val());
    end
    nq = $urandom_range(3, 8);
    for (int j = 0; j < nq; j++) begin
      k = $urandom_range(0, 19);
      span = xs[xs.size()-1] - xs[0];
      if (k < 14) q = xs[0] + longint'({$urandom, $urandom} % (span + 1));
      else if (k < 17) q = xs[$urandom_range(0, xs.size() - 1)];
      else q = longint'($signed($urandom));
      add_query(q[31:0]);
    end
  endtask

  function automatic int item_count();
    int c;
    c = 0;
    foreach (pending_items[i]) if (!pending_items[i].pause) c++;
    return c;
  endfunction

  // stimulus
  initial begin
    // empty table, then one knot: too few knots either way
    add_query(32'h0000_0000);
    add_knot(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_query(32'h8000_0000);
    // widest possible section with extreme slopes, so the sum saturates
    add_knot(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_query(32'h8000_0000);
    add_query(32'h7fff_ffff);
    add_query(32'h0000_0000);
    add_query(32'hc000_0000);
    // abscissa equal to and below the last one
    add_knot(1'b0, 32'h7fff_ffff, 32'h1, 32'h1);
    add_knot(1'b0, 32'h0000_0000, 32'h1, 32'h1);
    // restart with a small table of four knots
    add_knot(1'b1, 32'hfffe_0000, 32'h0001_0000, 32'h0000_0000);
    add_knot(1'b0, 32'h0000_0000, 32'hffff_0000, 32'h0002_0000);
    add_knot(1'b0, 32'h0001_8000, 32'h0003_0000, 32'hfffe_0000);
    add_knot(1'b0, 32'h0004_0000, 32'h0000_0000, 32'h0000_8000);
    // outside below and above, then on inner knots, the ends and one point inside a section
    add_query(32'hfffd_ffff);
    add_query(32'h0004_0001);
    add_query(32'h0000_0000);
    add_query(32'h0001_8000);
    add_query(32'hfffe_0000);
    add_query(32'h0004_0000);
    add_query(32'h0000_c000);
    // restart on top of a populated table
    add_knot(1'b1, 32'h7fff_fffe, 32'h1234_5678, 32'h8765_4321);
    add_query(32'h7fff_fffe);
    add_pause();
    add_spline_run(1'b1);
    while (item_count() < NUM_ITEMS) begin
      case ($urandom_range(0, 9))
        7: add_knot(1'b0, $urandom, rand_val(), rand_val());
        8: add_query($urandom);
        9: if ($urandom_range(0, 3) == 0) add_pause();
           else add_knot(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        default: add_spline_run($urandom_range(0, 14) == 0);
      endcase
    end
    add_pause();
    add_spline_run(1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || owed_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      $display("%0d results never arrived", owed_results.size());
      n_errors++;
    end
    $display("%0d items in, %0d results checked, %0d errors", n_sent, n_recv, n_errors);
    $display("%0d good evaluations, %0d error answers", n_eval_ok, n_err_status);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // input driver: offers pending items and records what each one should give
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        owed_results.push_back(spline_predict(cur));
        n_sent++;
        tx_gap = calm() ? 0 : $urandom_range(0, 3);
      end
      if (!(in_valid && in_stall)) begin
        // a pause marker holds the sender until the block has drained
        if (pending_items.size() != 0 && pending_items[0].pause &&
            owed_results.size() == 0 && tx_gap == 0)
          void'(pending_items.pop_front());
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 && !pending_items[0].pause) begin
          cur = pending_items.pop_front();
          mode       <= cur.mode;
          restart    <= cur.restart;
          knot_x     <= cur.kx;
          knot_y     <= cur.ky;
          knot_slope <= cur.ks;
          query_x    <= cur.qx;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started once partway through
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && n_sent >= 300) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    spline_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result, value", value, '0);
        end else begin
          want = owed_results.pop_front();
          if (value !== want.value) report_mismatch("value", value, want.value);
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
          if (section !== want.section)
            report_mismatch("section", 32'(section), 32'(want.section));
          if (want.status == ST_OK && want.value != 0) n_eval_ok++;
          if (want.status != ST_OK) n_err_status++;
        end
        n_recv++;
        rx_gap = calm() ? 0 : $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

endmodule
